[sv/lei_pkg.sv]
// Shared types and codes for the light-to-energy interpolator.
// No dependencies; the top level, the divider and the testbench import this package.
package lei_pkg;

  // Opcode values of a request.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  region;
    logic [31:0] total_energy;
    logic [31:0] deposited_energy;
    logic [31:0] light;
    logic        stopped;
  } in_item_t;

  typedef struct packed {
    logic [31:0] energy;
    logic [1:0]  status;
  } out_item_t;

  // One calibration entry as stored in the table memory.
  typedef struct packed {
    logic [31:0] total_energy;
    logic [31:0] deposited_energy;
    logic [31:0] light;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Start request to the divider: dividend high word is below the divisor.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

endpackage

[sv/lei_stream_if.sv]
// Valid/ready stream channel carrying one payload of type T.
// Depends on nothing; payload types come from lei_pkg.
interface lei_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/light_to_energy_interpolator.sv]
// Top level of the light-to-energy interpolator: table memory, walk and arithmetic.
// Depends on lei_pkg, lei_stream_if, lei_ram and lei_divider.
//
//   channel  direction  payload                                         handshake
//   req      in         opcode region total_energy deposited_energy     valid/ready
//                       light stopped
//   rsp      out        energy status                                   valid/ready
//
// An append, or a query on an empty table or an invalid region, goes straight to the output.
// Any other query walks the table, one table entry read per cycle from the table memory,
// then passes the evaluate state. A query that ends below the table stops there; a
// saturating extrapolation also passes the multiply state, and any other extrapolation
// or interpolation passes the multiply and divide states.
// Reset clears the per-region entry counts; the table memory needs no clearing.
// A finished result waits in the output register while the next request is taken.
module light_to_energy_interpolator import lei_pkg::*; #(
  parameter int ENTRIES_PER_REGION = 256,
  parameter int REGIONS            = 3
) (
  input logic               clk,
  input logic               rst,
  lei_stream_if.sink        req,
  lei_stream_if.source      rsp
);

  localparam int DEPTH = REGIONS * ENTRIES_PER_REGION;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(ENTRIES_PER_REGION + 1);
  localparam int RIW   = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  typedef enum logic [2:0] {IDLE, WALK, EVAL, MUL, DIV, DONE} state_t;

  state_t      state;
  logic [CW-1:0] cnt [REGIONS];
  logic [CW-1:0] n;
  logic [CW-1:0] k;
  logic [AW-1:0] base;
  logic [31:0] q_light;
  logic        q_stopped;
  logic        lo_found;
  logic        hi_found;
  logic [31:0] e_lo;
  logic [31:0] l_lo;
  logic [31:0] etot_lo;
  logic [31:0] e_hi;
  logic [31:0] l_hi;
  logic        extrap;
  logic        descend;
  logic [63:0] prod;
  logic        ov;
  out_item_t   out_q;
  out_item_t   res;

  logic [RIW-1:0] ridx;
  logic           reg_ok;
  logic [CW-1:0]  cnt_sel;
  logic [AW-1:0]  req_base;
  logic [CW-1:0]  rd_n;
  logic [CW-1:0]  rd_k;
  logic [AW-1:0]  rd_base;
  logic           rd_stop;
  logic [CW-1:0]  rd_ofs;
  logic [AW-1:0]  raddr;
  logic           ram_we;
  logic [AW-1:0]  waddr;
  logic [ENTRY_W-1:0] rdata;
  entry_t         ent;
  logic           w_kind;
  logic [31:0]    w_val;
  logic [31:0]    m_a;
  logic [31:0]    m_b;
  logic           sat_early;
  div_req_t       div_req;
  logic           div_done;
  logic [31:0]    quot;

  // Region decode for the incoming request.
  always_comb begin
    ridx     = RIW'(req.data.region);
    reg_ok   = 32'(req.data.region) < REGIONS;
    cnt_sel  = reg_ok ? cnt[ridx] : '0;
    req_base = AW'(32'(req.data.region) * ENTRIES_PER_REGION);
  end

  // Read address: the first entry on entry, the next entry while walking.
  always_comb begin
    if (state == IDLE) begin
      rd_n    = cnt_sel;
      rd_k    = '0;
      rd_base = req_base;
      rd_stop = req.data.stopped;
    end else begin
      rd_n    = n;
      rd_k    = k + CW'(1);
      rd_base = base;
      rd_stop = q_stopped;
    end
    rd_ofs = rd_stop ? rd_k : rd_n - rd_k - CW'(1);
    raddr  = rd_base + AW'(rd_ofs);
  end

  // Append write goes to the slot after the last stored entry.
  assign ram_we = (state == IDLE) && req.valid && (req.data.opcode == OP_APPEND) &&
                  reg_ok && (cnt_sel < CW'(ENTRIES_PER_REGION));
  assign waddr  = req_base + AW'(cnt_sel);

  lei_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({req.data.total_energy, req.data.deposited_energy, req.data.light}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Classification of the entry read back.
  always_comb begin
    ent    = entry_t'(rdata);
    w_kind = ent.deposited_energy >= ent.total_energy;
    w_val  = q_stopped ? ent.total_energy : ent.deposited_energy;
  end

  // Multiplier operands: light times low total energy, or offset times energy span.
  always_comb begin
    if (!hi_found) begin
      m_a = q_light;
      m_b = etot_lo;
    end else begin
      m_a = q_light - l_lo;
      m_b = (e_hi >= e_lo) ? e_hi - e_lo : e_lo - e_hi;
    end
  end

  // Extrapolation that saturates or divides by zero skips the divider.
  assign sat_early = extrap && ((l_lo == 32'd0) || (prod[63:32] >= l_lo));

  always_comb begin
    div_req.start = (state == MUL) && !sat_early;
    div_req.num   = prod;
    div_req.den   = extrap ? l_lo : l_hi - l_lo;
  end

  lei_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (quot)
  );

  // Sequencer, entry counts and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      ov    <= 1'b0;
      for (int i = 0; i < REGIONS; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      if (ov && rsp.ready && (state != DONE)) begin
        ov <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req.valid) begin
            res.energy <= 32'd0;
            if (req.data.opcode == OP_APPEND) begin
              if (ram_we) begin
                cnt[ridx] <= cnt_sel + CW'(1);
              end
              res.status <= ram_we ? ST_OK : ST_FULL;
              state      <= DONE;
            end else begin
              res.status <= ST_OK;
              q_light   <= req.data.light;
              q_stopped <= req.data.stopped;
              base      <= req_base;
              n         <= cnt_sel;
              k         <= '0;
              lo_found  <= 1'b0;
              hi_found  <= 1'b0;
              state     <= (cnt_sel == '0) ? DONE : WALK;
            end
          end
        end
        WALK: begin
          if (w_kind != q_stopped) begin
            state <= EVAL;
          end else if (ent.light > q_light) begin
            hi_found <= 1'b1;
            e_hi     <= w_val;
            l_hi     <= ent.light;
            state    <= EVAL;
          end else begin
            lo_found <= 1'b1;
            e_lo     <= w_val;
            l_lo     <= ent.light;
            etot_lo  <= ent.total_energy;
            if (k + CW'(1) == n) begin
              state <= EVAL;
            end else begin
              k <= k + CW'(1);
            end
          end
        end
        EVAL: begin
          if (!lo_found) begin
            res.energy <= hi_found ? e_hi : 32'd0;
            res.status <= ST_OK;
            state      <= DONE;
          end else begin
            prod    <= 64'(m_a) * 64'(m_b);
            extrap  <= !hi_found;
            descend <= e_hi < e_lo;
            state   <= MUL;
          end
        end
        MUL: begin
          if (sat_early) begin
            if (prod == 64'd0) begin
              res.energy <= 32'd0;
              res.status <= ST_OK;
            end else begin
              res.energy <= 32'hFFFF_FFFF;
              res.status <= ST_SAT;
            end
            state <= DONE;
          end else begin
            state <= DIV;
          end
        end
        DIV: begin
          if (div_done) begin
            if (extrap) begin
              res.energy <= quot;
            end else if (descend) begin
              res.energy <= e_lo - quot;
            end else begin
              res.energy <= e_lo + quot;
            end
            res.status <= ST_OK;
            state      <= DONE;
          end
        end
        DONE: begin
          if (!ov || rsp.ready) begin
            ov    <= 1'b1;
            out_q <= res;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign req.ready = (state == IDLE);
  assign rsp.valid = ov;
  assign rsp.data  = out_q;

  // A request taken closes the input until its result is staged.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in progress");

  // The divider is only started when the quotient fits 32 bits.
  a_div_fits: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (div_req.num[63:32] < div_req.den))
    else $error("divider started with an overflowing quotient");

  // The walk never reads past the region's stored entries.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == WALK) |-> (k < n))
    else $error("table walk beyond entry count");

endmodule

[sv/lei_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lei_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lei_divider.sv]
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on lei_pkg for the request struct.
module lei_divider import lei_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [31:0] quot
);

  localparam int STEPS = 32;

  logic        busy;
  logic [4:0]  step;
  logic [31:0] rem;
  logic [31:0] q;
  logic [31:0] den;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  // Trial subtraction of the shifted partial remainder.
  always_comb begin
    shifted = {rem, q[31]};
    diff    = shifted - {1'b0, den};
    ge      = !diff[32];
  end

  // Iteration control and remainder update.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= req.num[63:32];
        q    <= req.num[31:0];
        den  <= req.den;
      end else if (busy) begin
        rem  <= ge ? diff[31:0] : shifted[31:0];
        q    <= {q[30:0], ge};
        step <= step + 5'd1;
        if (step == 5'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule

[sim/lei_tb_if_note.sv]
`timescale 1ns / 100ps
// Small shared helpers for the interpolator testbench: an idle-pattern generator.
// Depends on nothing; used by light_to_energy_interpolator_tb.
module lei_idle_gen (
  input  logic clk,
  input  logic quiet,
  output logic idle
);
  // About 34 percent of cycles are idle unless a quiet stretch is active.
  always @(posedge clk) begin
    idle <= quiet ? 1'b0 : ($urandom_range(99) < 34);
  end
  initial idle = 1'b0;
endmodule

[sim/light_to_energy_interpolator_tb.sv]
`timescale 1ns / 100ps
// Testbench for light_to_energy_interpolator: drives appends and queries with random
// stalls, predicts each result with its own table model and checks energy and status.
// Depends on lei_pkg, lei_stream_if, the RTL and lei_idle_gen.
module light_to_energy_interpolator_tb;
  import lei_pkg::*;

  localparam int DEPTH = 256;
  localparam int NREG  = 3;
  localparam int IN_W  = $bits(in_item_t);

  logic clk;
  logic rst;
  logic quiet;
  logic send_idle, recv_idle;
  int   err_count;

  lei_stream_if #(in_item_t)  req ();
  lei_stream_if #(out_item_t) rsp ();

  light_to_energy_interpolator #(.ENTRIES_PER_REGION(DEPTH), .REGIONS(NREG)) DUT (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  lei_idle_gen send_gen (.clk(clk), .quiet(quiet), .idle(send_idle));
  lei_idle_gen recv_gen (.clk(clk), .quiet(quiet), .idle(recv_idle));

  // Predictor copy of the calibration tables.
  entry_t      cal_table [NREG][DEPTH];
  int unsigned cal_count [NREG];
  out_item_t   pending_results [$];

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Reports one mismatch and counts it.
  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Computes the energy result of one request and updates the table copy.
  function automatic out_item_t predict_energy(input in_item_t it);
    out_item_t r;
    int unsigned n, idx;
    bit lo_f, hi_f, st;
    logic [31:0] e_lo, l_lo, et_lo, e_hi, l_hi, v;
    logic [63:0] num, q, dl, span, mag, stp;
    r.energy = '0;
    r.status = ST_OK;
    lo_f = 0; hi_f = 0;
    e_lo = 0; l_lo = 0; et_lo = 0; e_hi = 0; l_hi = 0;
    if (it.opcode == OP_APPEND) begin
      if (it.region >= NREG || cal_count[it.region] >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        cal_table[it.region][cal_count[it.region]] =
          '{it.total_energy, it.deposited_energy, it.light};
        cal_count[it.region]++;
      end
      return r;
    end
    if (it.region >= NREG) return r;
    n = cal_count[it.region];
    for (int k = 0; k < n; k++) begin
      idx = it.stopped ? k : n - 1 - k;
      st = cal_table[it.region][idx].deposited_energy >=
           cal_table[it.region][idx].total_energy;
      if (st != it.stopped) break;
      v = it.stopped ? cal_table[it.region][idx].total_energy
                     : cal_table[it.region][idx].deposited_energy;
      if (cal_table[it.region][idx].light > it.light) begin
        hi_f = 1; e_hi = v; l_hi = cal_table[it.region][idx].light;
        break;
      end
      lo_f = 1; e_lo = v; l_lo = cal_table[it.region][idx].light;
      et_lo = cal_table[it.region][idx].total_energy;
    end
    if (!lo_f) begin
      r.energy = hi_f ? e_hi : '0;
    end else if (!hi_f) begin
      num = 64'(it.light) * 64'(et_lo);
      if (l_lo == 0) begin
        if (num != 0) begin r.energy = '1; r.status = ST_SAT; end
      end else begin
        q = num / 64'(l_lo);
        if (q > 64'hFFFF_FFFF) begin r.energy = '1; r.status = ST_SAT; end
        else r.energy = q[31:0];
      end
    end else begin
      dl = 64'(32'(it.light - l_lo));
      span = 64'(32'(l_hi - l_lo));
      if (e_hi >= e_lo) begin
        mag = 64'(32'(e_hi - e_lo)); stp = (dl * mag) / span;
        r.energy = e_lo + stp[31:0];
      end else begin
        mag = 64'(32'(e_lo - e_hi)); stp = (dl * mag) / span;
        r.energy = e_lo - stp[31:0];
      end
    end
    return r;
  endfunction

  // Sends one request and records the expected result at acceptance.
  // Valid stays high after acceptance so that requests can follow back to back.
  task automatic send_request(input in_item_t it);
    while (send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= it;
    do @(posedge clk); while (!req.ready);
    pending_results = {pending_results, predict_energy(it)};
  endtask

  function automatic in_item_t make_append(input logic [1:0] rg, input logic [31:0] e,
                                           input logic [31:0] de, input logic [31:0] l);
    in_item_t it;
    it = '{OP_APPEND, rg, e, de, l, 1'b0};
    return it;
  endfunction

  function automatic in_item_t make_query(input logic [1:0] rg, input logic [31:0] l,
                                          input logic st);
    in_item_t it;
    it = '{OP_QUERY, rg, $urandom, $urandom, l, st};
    return it;
  endfunction

  // Waits until every expected result has arrived.
  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Ready follows the receiver idle pattern.
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else     rsp.ready <= !recv_idle;
  end

  // Compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result %h", rsp.data));
      end else begin
        want = pending_results.pop_front();
        if (rsp.data.energy !== want.energy)
          report_error($sformatf("energy %h, expected %h", rsp.data.energy, want.energy));
        if (rsp.data.status !== want.status)
          report_error($sformatf("status %0d, expected %0d", rsp.data.status, want.status));
      end
    end
  end

  // Directed: empty tables, bad regions, both walk directions and all query cases.
  task automatic test_directed();
    send_request(make_query(2'd0, 32'h0001_0000, 1'b1));
    send_request(make_query(2'd3, 32'hFFFF_FFFF, 1'b0));
    send_request(make_append(2'd3, 32'h1, 32'h1, 32'h1));
    // Region 0 stopped entries with a zero-light entry first.
    send_request(make_append(2'd0, 32'h0010_0000, 32'h0010_0000, 32'h0));
    send_request(make_query(2'd0, 32'h0, 1'b1));
    send_request(make_query(2'd0, 32'h5, 1'b1));
    send_request(make_append(2'd0, 32'h0020_0000, 32'hFFFF_FFFF, 32'h0008_0000));
    send_request(make_append(2'd0, 32'h0001_0000, 32'h0001_0000, 32'h0010_0000));
    send_request(make_query(2'd0, 32'h0004_0000, 1'b1));
    send_request(make_query(2'd0, 32'h000C_0000, 1'b1));
    send_request(make_query(2'd0, 32'hFFFF_FFFF, 1'b1));
    send_request(make_query(2'd0, 32'h0001_0000, 1'b0));
    // Region 1 punched-through entries, walked backward.
    send_request(make_append(2'd1, 32'hFFFF_FFFF, 32'h0, 32'h0002_0000));
    send_request(make_append(2'd1, 32'h0080_0000, 32'h0040_0000, 32'h0004_0000));
    send_request(make_append(2'd1, 32'h0080_0000, 32'h0010_0000, 32'h0001_0000));
    send_request(make_query(2'd1, 32'h0, 1'b0));
    send_request(make_query(2'd1, 32'h0003_0000, 1'b0));
    send_request(make_query(2'd1, 32'h0000_8000, 1'b0));
    send_request(make_query(2'd1, 32'hFFFF_FFFF, 1'b0));
    send_request(make_query(2'd1, 32'h1, 1'b1));
    drain_results();
  endtask

  // Fills region 2 past its capacity with random entries and queries.
  task automatic test_table_full();
    logic [31:0] e;
    for (int k = 0; k < DEPTH + 4; k++) begin
      e = $urandom;
      send_request(make_append(2'd2, e, ($urandom_range(3) == 0) ? e - 1 : e + $urandom_range(9),
                               k * 32'h0100_0000 / DEPTH + $urandom_range(255)));
    end
    for (int k = 0; k < 30; k++)
      send_request(make_query(2'd2, $urandom, $urandom_range(1)));
  endtask

  // Random mix; mostly well-formed monotonic tables with random content.
  task automatic test_random(input int items);
    logic [31:0] lastl [2];
    logic [31:0] e;
    in_item_t it;
    lastl[0] = 0; lastl[1] = 0;
    for (int k = 0; k < items; k++) begin
      if (k == items / 3) begin
        drain_results();
        quiet <= 1'b1;
      end
      if (k == items / 2) quiet <= 1'b0;
      if ($urandom_range(99) < 40 && $urandom_range(3) != 0) begin
        int r;
        r = $urandom_range(1);
        e = $urandom;
        lastl[r] = lastl[r] + $urandom_range(32'h0100_0000);
        send_request(make_append(2'(r), e,
          $urandom_range(1) ? e + $urandom_range(32'hFFFF) : e - $urandom_range(32'hFFFF),
          $urandom_range(9) == 0 ? $urandom : lastl[r]));
      end else if ($urandom_range(9) == 0) begin
        it = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
        send_request(it);
      end else begin
        send_request(make_query(2'($urandom_range(2)),
          $urandom_range(1) ? $urandom : $urandom_range(lastl[0] + 32'h0100_0000),
          $urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    err_count = 0;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    foreach (cal_count[i]) cal_count[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(730);
    drain_results();
    repeat (400) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
